// ----- hdl/twz_pkg.sv -----
// Package for the zero-key TWINE permutation: S-box, nibble shuffle table
// and the single-round function. No dependencies.
`timescale 1ns / 1ps

package twz_pkg;

    localparam int BLOCK_W  = 64;
    localparam int NIB_W    = 4;
    localparam int NIB_N    = BLOCK_W / NIB_W;
    localparam int PAIR_N   = NIB_N / 2;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [NIB_W-1:0]   nibble_t;

    localparam nibble_t SBOX [NIB_N] = '{
        4'hC, 4'h0, 4'hF, 4'hA, 4'h2, 4'hB, 4'h9, 4'h5,
        4'h8, 4'h3, 4'hD, 4'h7, 4'h1, 4'hE, 4'h6, 4'h4
    };

    // Destination position of each nibble after the shuffle
    localparam nibble_t PERM [NIB_N] = '{
        4'd5,  4'd0,  4'd1,  4'd4,  4'd7,  4'd12, 4'd3,  4'd8,
        4'd13, 4'd6,  4'd9,  4'd2,  4'd15, 4'd10, 4'd11, 4'd14
    };

    // One round: odd nibble of each pair is XORed with the S-box of its even
    // partner, then the nibbles move by PERM unless shuffle is low (last round).
    function automatic block_t twz_round_f(input block_t d, input logic shuffle);
        nibble_t nib [NIB_N];
        block_t  res;
        for (int i = 0; i < NIB_N; i++)
        begin
            nib[i] = d[NIB_W*i +: NIB_W];
        end
        for (int j = 0; j < PAIR_N; j++)
        begin
            nib[2*j+1] = nib[2*j+1] ^ SBOX[nib[2*j]];
        end
        res = '0;
        for (int i = 0; i < NIB_N; i++)
        begin
            if (shuffle)
            begin
                res[NIB_W*PERM[i] +: NIB_W] = nib[i];
            end
            else
            begin
                res[NIB_W*i +: NIB_W] = nib[i];
            end
        end
        return res;
    endfunction

endpackage

// ----- hdl/twz_round.sv -----
// One pipeline stage of the zero-key TWINE permutation: one round and its
// register, with a valid bit and a bubble-collapsing ready. Uses twz_pkg.
`timescale 1ns / 1ps

module twz_round #(
    parameter bit SHUFFLE = 1'b1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  twz_pkg::block_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output twz_pkg::block_t out_data
);
    import twz_pkg::*;

    logic   valid_reg;
    block_t data_reg;
    block_t data_next;

    // Advance when this stage is empty or its item leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign data_next = twz_round_f(in_data, SHUFFLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/twine_zero_key_permutation.sv -----
// Top level of the zero-key TWINE permutation: a chain of twz_round stages
// between two stream ports. Uses twz_pkg and twz_round.
`timescale 1ns / 1ps

// Maps each 64-bit block to the 64-bit block left by ROUND_COUNT rounds of the
// TWINE generalised Feistel network with all round keys zero (the last round
// has no nibble shuffle). One round sits in each register stage, so a block
// enters every cycle while the output side keeps up, and its result reaches the
// output after passing through every round stage in order. Each stage carries
// its own valid bit and takes a new item whenever it is empty or its item moves
// on, so bubbles close up during a stall and nothing is lost or repeated. The
// last stage is the output register. No state survives between items and reset
// only clears the valid bits; there is nothing to configure.
module twine_zero_key_permutation #(
    parameter int ROUND_COUNT = 36
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  twz_pkg::block_t s_axis_tdata,   // [63:0] block_in
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output twz_pkg::block_t m_axis_tdata    // [63:0] block_out
);
    import twz_pkg::*;

    // Index 0 is the input side; index k+1 is the output of round g_round[k]
    logic   [ROUND_COUNT:0] stage_valid;
    logic   [ROUND_COUNT:0] stage_ready;
    block_t                 stage_data [ROUND_COUNT+1];

    assign stage_valid[0] = s_axis_tvalid;
    assign stage_data[0]  = s_axis_tdata;
    assign s_axis_tready  = stage_ready[0];

    generate
        for (genvar k = 0; k < ROUND_COUNT; k++)
        begin : g_round
            // Every round but the last shuffles the nibbles
            twz_round #(
                .SHUFFLE (k < ROUND_COUNT - 1)
            ) u_round (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stage_valid[k]),
                .in_ready  (stage_ready[k]),
                .in_data   (stage_data[k]),
                .out_valid (stage_valid[k+1]),
                .out_ready (stage_ready[k+1]),
                .out_data  (stage_data[k+1])
            );
        end
    endgenerate

    assign stage_ready[ROUND_COUNT] = m_axis_tready;
    assign m_axis_tvalid            = stage_valid[ROUND_COUNT];
    assign m_axis_tdata             = stage_data[ROUND_COUNT];

`ifndef NO_ASSERTIONS
    // A taken output frees every stage, so the input must be ready too
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is taken");

    // The input only stalls when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> ($countones(stage_valid[ROUND_COUNT:1]) == ROUND_COUNT))
    else $error("input stalled with a bubble in the pipeline");

    // An output item held back stays in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> stage_valid[ROUND_COUNT])
    else $error("stalled output item lost");
`endif

endmodule
